// ===== sv/aksp_pkg.sv =====
// Package for the aging keyed slot pool: field widths, action and outcome
// codes, controller state type and a helper function. No dependencies.
package aksp_pkg;

  localparam int unsigned SlotsPerClassDefault = 256;
  localparam int unsigned ClassCountDefault    = 3;

  localparam int unsigned KeyW     = 32;
  localparam int unsigned FrameW   = 32;
  localparam int unsigned SizeW    = 12;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 12;

  localparam logic [SizeW-1:0] TinyLimitReset  = 12'd8;
  localparam logic [SizeW-1:0] SmallLimitReset = 12'd64;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TINY_LIMIT  = 3'd0,
    REG_SMALL_LIMIT = 3'd1,
    REG_TINY_SLOTS  = 3'd2,
    REG_SMALL_SLOTS = 3'd3,
    REG_BIG_SLOTS   = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    ACT_GET   = 2'd0,
    ACT_PEEK  = 2'd1,
    ACT_FRAME = 2'd2,
    ACT_USAGE = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    OUT_HIT       = 3'd0,
    OUT_NEW_EMPTY = 3'd1,
    OUT_COLD      = 3'd2,
    OUT_EVICT     = 3'd3,
    OUT_PEEK_MISS = 3'd4,
    OUT_FRAME     = 3'd5,
    OUT_USAGE     = 3'd6
  } outcome_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HOME,
    ST_READ,
    ST_PROBE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // A stamp is live when it is at most one frame behind the current frame.
  function automatic logic is_live(input logic [FrameW-1:0] now,
                                   input logic [FrameW-1:0] stamp);
    logic [FrameW-1:0] age;
    age = now - stamp;
    return (age <= FrameW'(1));
  endfunction

endpackage

// ===== sv/aksp_slot_mem.sv =====
// Slot memory for the aging keyed slot pool: key and stamp per slot, one
// write and one registered read port, with a clearing pass after reset. Uses aksp_pkg.
module aksp_slot_mem
  import aksp_pkg::*;
#(
  parameter int unsigned DEPTH = 768
) (
  input  logic                     clk,
  input  logic                     rst_n,
  output logic                     clr_busy,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [KeyW-1:0]          rd_key,
  output logic [FrameW-1:0]        rd_stamp,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [KeyW-1:0]          wr_key,
  input  logic [FrameW-1:0]        wr_stamp
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [KeyW+FrameW-1:0] mem [DEPTH];
  logic [KeyW+FrameW-1:0] rd_data_r;
  logic                   clr_busy_r;
  logic [AW-1:0]          clr_addr_r;

  // Clearing pass: after reset every entry is written with zero, one per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      if (clr_addr_r == AW'(DEPTH - 1)) clr_busy_r <= 1'b0;
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  // Array storage, registered read.
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= {wr_stamp, wr_key};
    end
    rd_data_r <= mem[rd_addr];
  end

  assign clr_busy = clr_busy_r;
  assign rd_key   = rd_data_r[KeyW-1:0];
  assign rd_stamp = rd_data_r[KeyW+FrameW-1:KeyW];

endmodule

// ===== sv/aging_keyed_slot_pool.sv =====
// Top level of the aging keyed slot pool: configuration registers, the probe
// controller and the slot memory. Uses aksp_pkg and aksp_slot_mem.
//
// Usage: items enter on the in_ stream (action, key, tenant_size) and each
// produces exactly one result item on the out_ stream. Configuration is
// written through cfg_we/cfg_idx/cfg_data while the block is idle.
// One item is processed at a time. A get or peek passes through the home,
// read and probe states and registers its result in the probe state; each
// further slot probed adds one memory read and one decision. The write-back
// of a get happens at the same edge that registers the result, and the next
// item can be accepted in the cycle after. Frame advance registers its
// result in the done state. A usage count reads the whole class table in
// the scan state before it registers its result. Results sit in an output
// register; the next item is accepted as soon as the controller is idle,
// even while a result waits for out_tready. The controller stalls while the
// output register is full and a new result is ready. Reset (rst_n low,
// synchronous) sets the frame counter to zero and loads the configuration
// reset values; a clearing pass over all CLASS_COUNT * SLOTS_PER_CLASS
// entries (768 by default) then empties all tables, with in_tready low
// until it is done.
module aging_keyed_slot_pool
  import aksp_pkg::*;
#(
  parameter int unsigned SLOTS_PER_CLASS = SlotsPerClassDefault,
  parameter int unsigned CLASS_COUNT     = ClassCountDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // in_tdata: action[1:0], key[33:2], tenant_size[45:34], zero fill to 48
  input  logic [47:0]         in_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  // out_tdata: outcome[2:0], class_used[4:3], slot_index[12:5],
  // zero_payload[13], live_count[22:14], used_count[31:23]
  output logic [31:0]         out_tdata,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_idx,
  input  logic [CfgDataW-1:0] cfg_data
);

  localparam int unsigned SW    = $clog2(SLOTS_PER_CLASS);
  localparam int unsigned CW    = SW + 1;
  localparam int unsigned DEPTH = CLASS_COUNT * SLOTS_PER_CLASS;
  localparam int unsigned AW    = $clog2(DEPTH);

  // Configuration registers.
  logic [SizeW-1:0] tiny_lim_r, small_lim_r;
  logic [8:0]       slots_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tiny_lim_r  <= TinyLimitReset;
      small_lim_r <= SmallLimitReset;
      slots_r[0]  <= 9'd256;
      slots_r[1]  <= 9'd256;
      slots_r[2]  <= 9'd256;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_idx))
        REG_TINY_LIMIT:  tiny_lim_r  <= cfg_data;
        REG_SMALL_LIMIT: small_lim_r <= cfg_data;
        REG_TINY_SLOTS:  slots_r[0]  <= cfg_data[8:0];
        REG_SMALL_SLOTS: slots_r[1]  <= cfg_data[8:0];
        REG_BIG_SLOTS:   slots_r[2]  <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Item registers.
  state_t            st_r, st_nxt;
  action_t           act_r;
  logic [KeyW-1:0]   key_r;
  logic [1:0]        cls_r;
  logic [CW-1:0]     n_r;
  logic [SW-1:0]     home_r, b_r, cold_r;
  logic              have_cold_r;
  logic [CW-1:0]     cnt_r;
  logic [FrameW-1:0] frame_r;
  logic [31:0]       prod_r;
  logic [8:0]        live_r, used_r;
  logic              ovld_r;
  logic [31:0]       odata_r;
  logic              scan_rd_r, scan_end_r;

  // Class pick and slot count of the incoming item.
  logic [SizeW-1:0] in_size;
  logic [KeyW-1:0]  in_key;
  logic [1:0]       in_cls;
  logic [8:0]       in_raw;
  logic [CW-1:0]    in_n;

  always_comb begin
    in_size = in_tdata[45:34];
    in_key  = (in_tdata[33:2] == '0) ? KeyW'(1) : in_tdata[33:2];
    if (in_size <= tiny_lim_r)       in_cls = 2'd0;
    else if (in_size <= small_lim_r) in_cls = 2'd1;
    else                             in_cls = 2'd2;
    if (32'(in_cls) >= CLASS_COUNT) in_cls = 2'(CLASS_COUNT - 1);
    in_raw = slots_r[in_cls];
    if (in_raw == '0) in_n = CW'(1);
    else if (32'(in_raw) > SLOTS_PER_CLASS) in_n = CW'(SLOTS_PER_CLASS);
    else in_n = CW'(in_raw);
  end

  // Memory read and write side.
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [KeyW-1:0]   rd_key, wr_key;
  logic [FrameW-1:0] rd_stamp;
  logic              wr_en;
  logic              clr_busy;
  logic [SW-1:0]     b_inc, slot_w;
  logic              res_ok;
  logic              fin;
  logic [2:0]        res_oc;
  logic [SW-1:0]     res_slot;
  logic              res_zero;

  assign b_inc  = (CW'(b_r) + CW'(1) == n_r) ? '0 : b_r + SW'(1);
  assign rd_addr = AW'(32'(cls_r) * SLOTS_PER_CLASS + 32'(b_r));

  aksp_slot_mem #(.DEPTH(DEPTH)) u_mem (
    .clk(clk), .rst_n(rst_n), .clr_busy(clr_busy),
    .rd_addr(rd_addr), .rd_key(rd_key), .rd_stamp(rd_stamp),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_key(wr_key), .wr_stamp(frame_r)
  );

  assign res_ok    = !ovld_r || out_tready;
  assign in_tready = (st_r == ST_IDLE) && !clr_busy;

  // Probe decisions on the slot just read.
  logic hit, empty, cold, last;
  assign hit   = (rd_key == key_r);
  assign empty = (rd_key == '0);
  assign cold  = !is_live(frame_r, rd_stamp);
  assign last  = (cnt_r + CW'(1) == n_r);

  always_comb begin
    fin      = 1'b0;
    res_oc   = OUT_HIT;
    res_slot = '0;
    res_zero = 1'b0;
    wr_en    = 1'b0;
    slot_w   = b_r;
    if (st_r == ST_PROBE) begin
      if (act_r == ACT_PEEK) begin
        if (hit) begin
          fin = 1'b1; res_slot = b_r;
        end else if (empty || last) begin
          fin = 1'b1; res_oc = OUT_PEEK_MISS;
        end
      end else begin
        if (hit) begin
          fin = 1'b1; res_slot = b_r;
        end else if (empty || last) begin
          fin = 1'b1; res_zero = 1'b1;
          if (have_cold_r)       begin res_oc = OUT_COLD;  slot_w = cold_r; end
          else if (!empty && cold) begin res_oc = OUT_COLD; slot_w = b_r; end
          else if (empty)        begin res_oc = OUT_NEW_EMPTY; slot_w = b_r; end
          else                   begin res_oc = OUT_EVICT; slot_w = home_r; end
          res_slot = slot_w;
        end
      end
      wr_en = fin && (act_r == ACT_GET) && res_ok;
    end
    wr_addr = AW'(32'(cls_r) * SLOTS_PER_CLASS + 32'(slot_w));
    wr_key  = key_r;
  end

  // Next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:  if (in_tvalid && in_tready) begin
        case (action_t'(in_tdata[1:0]))
          ACT_FRAME: st_nxt = ST_DONE;
          ACT_USAGE: st_nxt = ST_SCAN;
          default:   st_nxt = ST_HOME;
        endcase
      end
      ST_HOME:  st_nxt = ST_READ;
      ST_READ:  st_nxt = ST_PROBE;
      ST_PROBE: if (fin) begin
        if (res_ok) st_nxt = ST_IDLE;
      end else st_nxt = ST_READ;
      ST_SCAN:  if (cnt_r == n_r && res_ok) st_nxt = ST_IDLE;
      ST_DONE:  if (res_ok) st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      frame_r <= '0;
      ovld_r  <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (out_tready) ovld_r <= 1'b0;
      case (st_r)
        ST_IDLE: if (in_tvalid && in_tready) begin
          act_r       <= action_t'(in_tdata[1:0]);
          key_r       <= in_key;
          cls_r       <= in_cls;
          n_r         <= in_n;
          // Home bucket is the upper word of key times slot count.
          prod_r      <= 32'(({32'b0, in_key} * 64'(in_n)) >> 32);
          have_cold_r <= 1'b0;
          cnt_r       <= '0;
          b_r         <= '0;
          live_r      <= '0;
          used_r      <= '0;
          scan_rd_r   <= 1'b0;
        end
        ST_HOME: begin
          home_r <= prod_r[SW-1:0];
          b_r    <= prod_r[SW-1:0];
        end
        ST_PROBE: if (fin) begin
          if (res_ok) begin
            ovld_r  <= 1'b1;
            odata_r <= {9'd0, 9'd0, res_zero, 8'(res_slot), cls_r, res_oc};
          end
        end else begin
          if (!have_cold_r && cold) begin
            have_cold_r <= 1'b1;
            cold_r      <= b_r;
          end
          b_r   <= b_inc;
          cnt_r <= cnt_r + CW'(1);
        end
        ST_SCAN: begin
          // Pipelined sweep: the address runs ahead, its data arriving in the cycle after.
          scan_rd_r <= (CW'(b_r) < n_r) && !scan_end_r;
          if (scan_rd_r) begin
            cnt_r <= cnt_r + CW'(1);
            if (!empty) begin
              used_r <= used_r + 9'd1;
              if (!cold) live_r <= live_r + 9'd1;
            end
          end
          if (!scan_end_r) begin
            if (CW'(b_r) + CW'(1) == n_r) scan_end_r <= 1'b1;
            else b_r <= b_r + SW'(1);
          end
          if (cnt_r == n_r && res_ok) begin
            ovld_r  <= 1'b1;
            odata_r <= {used_r, live_r, 1'b0, 8'd0, cls_r, OUT_USAGE};
          end
        end
        ST_DONE: if (res_ok) begin
          frame_r <= frame_r + FrameW'(1);
          ovld_r  <= 1'b1;
          odata_r <= {9'd0, 9'd0, 1'b0, 8'd0, 2'd0, OUT_FRAME};
        end
        default: ;
      endcase
      if (st_r == ST_IDLE) scan_end_r <= 1'b0;
    end
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = odata_r;

  logic unused_in;
  assign unused_in = ^in_tdata[47:46] ^ ^prod_r[31:SW];

endmodule

// ===== tb/tb_top.sv =====
// Testbench for the aging keyed slot pool: a directed table followed by random
// get/peek/frame/usage items, all checked against an in-bench slot table model.
// Depends on aksp_pkg and aging_keyed_slot_pool.
`timescale 1ns / 100ps

module tb_top;
  import aksp_pkg::*;

  localparam int unsigned NSlots = 256;
  localparam int unsigned RandItems = 1800;
  localparam int unsigned CycleLimit = 900000;

  typedef struct packed {
    logic [8:0] used_cnt;
    logic [8:0] live_cnt;
    logic       zero_pl;
    logic [7:0] slot;
    logic [1:0] cls;
    outcome_t   outcome;
  } pool_result_t;

  typedef struct {
    action_t    act;
    logic [31:0] key;
    logic [11:0] size;
    logic       has_exp;
    outcome_t   exp_outcome;
    logic [1:0] exp_cls;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [47:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [31:0] out_tdata;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  aging_keyed_slot_pool i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  // Shadow copy of the pool state and configuration.
  logic [31:0] key_mem [3*NSlots];
  logic [31:0] stamp_mem [3*NSlots];
  logic [31:0] frame_no;
  logic [11:0] tiny_lim, small_lim;
  logic [8:0]  slots_cfg [3];

  pool_result_t expected_results[$];
  int errors = 0;
  int cycle = 0;
  bit sink_hold = 0;
  bit calm = 0;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [1:0] class_of(logic [11:0] size);
    if (size <= tiny_lim) return 2'd0;
    if (size <= small_lim) return 2'd1;
    return 2'd2;
  endfunction

  function automatic int unsigned table_size(logic [1:0] c);
    int unsigned n;
    n = slots_cfg[c];
    if (n == 0) n = 1;
    if (n > NSlots) n = NSlots;
    return n;
  endfunction

  function automatic bit is_cold(logic [31:0] stamp);
    logic [31:0] age;
    age = frame_no - stamp;
    return age > 32'd1;
  endfunction

  // Works out the result of one item and updates the shadow state.
  function automatic pool_result_t predict_pool(action_t act, logic [31:0] key_in,
                                                logic [11:0] size);
    pool_result_t r;
    logic [1:0] c;
    int unsigned n, base, b, home, cold_b, empty_b;
    bit hit, have_cold, have_empty;
    logic [31:0] k, key;
    logic [63:0] prod;
    r = '0;
    key = (key_in == 0) ? 32'd1 : key_in;
    c = class_of(size);
    n = table_size(c);
    base = c * NSlots;
    prod = 64'(key) * 64'(n);
    home = prod[63:32];
    r.cls = c;
    hit = 0; have_cold = 0; have_empty = 0; cold_b = 0; empty_b = 0;
    case (act)
      ACT_FRAME: begin
        frame_no = frame_no + 1;
        r.outcome = OUT_FRAME;
        r.cls = 0;
      end
      ACT_USAGE: begin
        for (int i = 0; i < n; i++) begin
          if (key_mem[base+i] != 0) begin
            r.used_cnt++;
            if (!is_cold(stamp_mem[base+i])) r.live_cnt++;
          end
        end
        r.outcome = OUT_USAGE;
      end
      ACT_PEEK: begin
        r.outcome = OUT_PEEK_MISS;
        b = home;
        for (int i = 0; i < n; i++) begin
          k = key_mem[base+b];
          if (k == key) begin
            r.outcome = OUT_HIT;
            r.slot = 8'(b);
            break;
          end
          if (k == 0) break;
          b = (b + 1 == n) ? 0 : b + 1;
        end
      end
      default: begin
        b = home;
        for (int i = 0; i < n; i++) begin
          k = key_mem[base+b];
          if (k == key) begin
            hit = 1;
            r.slot = 8'(b);
            break;
          end
          if (k == 0) begin
            have_empty = 1;
            empty_b = b;
            break;
          end
          if (!have_cold && is_cold(stamp_mem[base+b])) begin
            have_cold = 1;
            cold_b = b;
          end
          b = (b + 1 == n) ? 0 : b + 1;
        end
        if (hit) r.outcome = OUT_HIT;
        else begin
          if (have_cold) begin
            r.slot = 8'(cold_b); r.outcome = OUT_COLD;
          end else if (have_empty) begin
            r.slot = 8'(empty_b); r.outcome = OUT_NEW_EMPTY;
          end else begin
            r.slot = 8'(home); r.outcome = OUT_EVICT;
          end
          key_mem[base+r.slot] = key;
          r.zero_pl = 1;
        end
        stamp_mem[base+r.slot] = frame_no;
      end
    endcase
    return r;
  endfunction

  // Result side: random stalls, and a long hold-off when asked.
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 0;
    else out_tready <= !sink_hold && (calm || $urandom_range(99) >= 9);
  end

  always @(posedge clk) begin
    pool_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_results.size() == 0) begin
        $error("result item with nothing expected: %h", out_tdata);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (got.outcome !== want.outcome) begin
          $error("outcome: expected %0d, got %0d", want.outcome, got.outcome); errors++;
        end
        if (got.cls !== want.cls) begin
          $error("class_used: expected %0d, got %0d", want.cls, got.cls); errors++;
        end
        if (got.slot !== want.slot) begin
          $error("slot_index: expected %0d, got %0d", want.slot, got.slot); errors++;
        end
        if (got.zero_pl !== want.zero_pl) begin
          $error("zero_payload: expected %0d, got %0d", want.zero_pl, got.zero_pl);
          errors++;
        end
        if (got.live_cnt !== want.live_cnt) begin
          $error("live_count: expected %0d, got %0d", want.live_cnt, got.live_cnt);
          errors++;
        end
        if (got.used_cnt !== want.used_cnt) begin
          $error("used_count: expected %0d, got %0d", want.used_cnt, got.used_cnt);
          errors++;
        end
      end
    end
  end

  // Offers one item, with an optional idle gap, and records its expectation.
  // The valid line stays high after acceptance; the next item or the drain
  // takes it down.
  task automatic send_item(action_t act, logic [31:0] key, logic [11:0] size,
                           bit has_exp = 0, outcome_t eo = OUT_HIT, logic [1:0] ec = 0);
    pool_result_t r;
    while (!calm && $urandom_range(99) < 9) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {2'b00, size, key, act};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = predict_pool(act, key, size);
    if (has_exp && (r.outcome !== eo || r.cls !== ec)) begin
      $error("table row disagrees with model: outcome %0d, class %0d", r.outcome, r.cls);
      errors++;
    end
    expected_results.push_back(r);
  endtask

  task automatic drain_results();
    in_tvalid <= 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (NSlots + 20) @(posedge clk);
  endtask

  // Drives one register write; the caller drops cfg_we after the last one.
  task automatic write_reg(reg_idx_t idx, logic [11:0] val);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_TINY_LIMIT:  tiny_lim = val;
      REG_SMALL_LIMIT: small_lim = val;
      REG_TINY_SLOTS:  slots_cfg[0] = val[8:0];
      REG_SMALL_SLOTS: slots_cfg[1] = val[8:0];
      default:         slots_cfg[2] = val[8:0];
    endcase
  endtask

  // Keys drawn from a small pool so that hits and chains are common.
  function automatic logic [31:0] pick_key();
    case ($urandom_range(9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom();
      default: return {4'($urandom_range(15)), 28'h0} | 32'($urandom_range(23));
    endcase
  endfunction

  function automatic action_t pick_action();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 60) return ACT_GET;
    if (p < 80) return ACT_PEEK;
    if (p < 93) return ACT_FRAME;
    return ACT_USAGE;
  endfunction

  stim_row_t directed_rows[] = '{
    '{ACT_USAGE, 32'd0, 12'd0, 1, OUT_USAGE, 2'd0},
    '{ACT_PEEK, 32'd0, 12'd0, 1, OUT_PEEK_MISS, 2'd0},
    '{ACT_GET, 32'd0, 12'd0, 1, OUT_NEW_EMPTY, 2'd0},
    '{ACT_GET, 32'd1, 12'd8, 1, OUT_HIT, 2'd0},
    '{ACT_PEEK, 32'd1, 12'd3, 1, OUT_HIT, 2'd0},
    '{ACT_GET, 32'hFFFF_FFFF, 12'd9, 1, OUT_NEW_EMPTY, 2'd1},
    '{ACT_GET, 32'hFFFF_FFFF, 12'd64, 1, OUT_HIT, 2'd1},
    '{ACT_GET, 32'h8000_0000, 12'd65, 1, OUT_NEW_EMPTY, 2'd2},
    '{ACT_GET, 32'h8000_0001, 12'd4095, 0, OUT_HIT, 2'd0},
    '{ACT_GET, 32'h8000_0002, 12'd4095, 0, OUT_HIT, 2'd0},
    '{ACT_PEEK, 32'h8000_0002, 12'd4095, 0, OUT_HIT, 2'd0},
    '{ACT_USAGE, 32'd0, 12'd4095, 0, OUT_HIT, 2'd0},
    '{ACT_FRAME, 32'h1234, 12'd4095, 1, OUT_FRAME, 2'd0},
    '{ACT_FRAME, 32'd0, 12'd0, 1, OUT_FRAME, 2'd0},
    '{ACT_USAGE, 32'd0, 12'd100, 0, OUT_HIT, 2'd0},
    '{ACT_FRAME, 32'd0, 12'd0, 1, OUT_FRAME, 2'd0},
    '{ACT_GET, 32'h8000_0003, 12'd100, 0, OUT_HIT, 2'd0},
    '{ACT_USAGE, 32'd0, 12'd100, 0, OUT_HIT, 2'd0},
    '{ACT_PEEK, 32'h7777_7777, 12'd20, 1, OUT_PEEK_MISS, 2'd1}
  };

  // Configuration phases: limits and slot counts, extremes included.
  logic [11:0] phase_cfg [6][5] = '{
    '{12'd8, 12'd64, 12'd256, 12'd256, 12'd256},
    '{12'd0, 12'd4095, 12'd1, 12'd4, 12'd3},
    '{12'd4095, 12'd0, 12'd0, 12'd1, 12'd511},
    '{12'd2000, 12'd100, 12'd257, 12'd2, 12'd5},
    '{12'd100, 12'd2000, 12'd7, 12'd16, 12'd8},
    '{12'd30, 12'd3000, 12'd256, 12'd32, 12'd256}
  };

  initial begin
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    cfg_we = 0;
    cfg_idx = REG_TINY_LIMIT;
    cfg_data = '0;
    for (int i = 0; i < 3*NSlots; i++) begin
      key_mem[i] = 0;
      stamp_mem[i] = 0;
    end
    frame_no = 0;
    tiny_lim = 8;
    small_lim = 64;
    for (int i = 0; i < 3; i++) slots_cfg[i] = 256;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_item(directed_rows[i].act, directed_rows[i].key, directed_rows[i].size,
                directed_rows[i].has_exp, directed_rows[i].exp_outcome,
                directed_rows[i].exp_cls);
    drain_results();

    // Receiver holds off while the sender keeps offering items.
    fork
      begin
        sink_hold = 1;
        repeat (300) @(posedge clk);
        sink_hold = 0;
      end
      for (int i = 0; i < 20; i++) send_item(ACT_GET, pick_key(), 12'($urandom_range(4095)));
    join
    drain_results();

    for (int ph = 0; ph < 6; ph++) begin
      for (int r = 0; r < 5; r++) write_reg(reg_idx_t'(r), phase_cfg[ph][r]);
      cfg_we <= 0;
      calm = (ph == 2);
      for (int i = 0; i < RandItems / 6; i++)
        send_item(pick_action(), pick_key(), 12'($urandom_range(4095)));
      drain_results();
    end
    calm = 0;

    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
